/* rtl/pblm_pkg.sv */
// pblm_pkg: shared constants, command codes and types of the prefix bitmap block.
// Geometry of the bitmap store (word width, row count) follows from ADDR_BITS.
// No dependencies.
`timescale 1ns / 1ps

package pblm_pkg;

  // Address width and derived widths
  localparam int ADDR_BITS = 16;
  localparam int IDX_W     = ADDR_BITS + 1;            // bitmap index width
  localparam int LEN_W     = $clog2(ADDR_BITS + 1);    // prefix length width

  // Bitmap store: rows of WORD_W bits
  localparam int WORD_LG   = (ADDR_BITS >= 6) ? 5 : 1;
  localparam int WORD_W    = 1 << WORD_LG;
  localparam int ROW_AW    = IDX_W - WORD_LG;
  localparam int RAM_DEPTH = 1 << ROW_AW;

  // Command codes
  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_DEL   = 2'd2;

  // Control of the slot index unit
  typedef struct packed {
    logic load;   // start a walk at length ADDR_BITS
    logic step;   // go one prefix length shorter
  } slot_ctrl_t;

endpackage

/* rtl/pblm_ram.sv */
// pblm_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module pblm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pblm_slot_unit.sv */
// pblm_slot_unit: shared shift/add unit that walks prefix lengths downward
// and forms the bitmap index (2^n - 2) + (top n address bits). Uses pblm_pkg.
`timescale 1ns / 1ps

module pblm_slot_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pblm_pkg::slot_ctrl_t           ctrl_i,
  input  logic [pblm_pkg::ADDR_BITS-1:0] addr_i,
  output logic [pblm_pkg::LEN_W-1:0]     len_o,
  output logic [pblm_pkg::IDX_W-1:0]     idx_o
);
  import pblm_pkg::*;

  logic [ADDR_BITS-1:0] val_q, val_d;   // top n address bits, right aligned
  logic [IDX_W-1:0]     pow_q, pow_d;   // 2^n
  logic [LEN_W-1:0]     len_q, len_d;   // current length n

  // Load or shift one length shorter
  always_comb begin
    val_d = val_q;
    pow_d = pow_q;
    len_d = len_q;
    if (ctrl_i.load) begin
      val_d = addr_i;
      pow_d = IDX_W'(1) << ADDR_BITS;
      len_d = LEN_W'(ADDR_BITS);
    end else if (ctrl_i.step) begin
      val_d = val_q >> 1;
      pow_d = pow_q >> 1;
      len_d = len_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    pow_q <= pow_d;
  end

  // Group base plus prefix value
  assign idx_o = pow_q - IDX_W'(2) + IDX_W'(val_q);
  assign len_o = len_q;

endmodule

/* rtl/prefix_bitmap_longest_match_core.sv */
// prefix_bitmap_longest_match_core: top level of the prefix presence bitmap.
// Uses pblm_pkg, pblm_slot_unit and pblm_ram.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   command   | start / busy         | cmd_i, addr_i, prefix_len_i
//   result    | done_o (1-cycle)     | ok_o, match_len_o, match_index_o
//
// After reset the bitmap rows are cleared, one row per cycle, with busy high;
// the store has RAM_DEPTH rows (4096 at 16 address bits).
// check: one probe per cycle through the single read port of the bitmap RAM,
// longest length first, stopping on a hit.
// add/delete: length walk, row read, then row write. Unused command, or
// add/delete with bad length: result in the cycle after the transaction.
// The result receiver cannot stall; done_o is a one-cycle strobe.
`timescale 1ns / 1ps

module prefix_bitmap_longest_match_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd_i,
  input  logic [pblm_pkg::ADDR_BITS-1:0] addr_i,
  input  logic [pblm_pkg::LEN_W-1:0]     prefix_len_i,
  output logic                           done_o,
  output logic                           ok_o,
  output logic [pblm_pkg::LEN_W-1:0]     match_len_o,
  output logic [pblm_pkg::IDX_W-1:0]     match_index_o
);
  import pblm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEEK,
    S_RMW,
    S_PROBE
  } state_e;

  state_e            state_q, state_d;
  logic [ROW_AW-1:0] clr_q, clr_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              pend_q, pend_d;      // probe read in flight
  logic [LEN_W-1:0]  pend_len_q, pend_len_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic              done_q, done_d;
  logic              ok_q, ok_d;
  logic [LEN_W-1:0]  mlen_q, mlen_d;
  logic [IDX_W-1:0]  midx_q, midx_d;

  slot_ctrl_t        slot_ctrl;
  logic [LEN_W-1:0]  slot_len;
  logic [IDX_W-1:0]  slot_idx;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              accept;
  logic              len_ok;
  logic              cur_bit;
  logic              pend_bit;

  pblm_slot_unit u_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (slot_ctrl),
    .addr_i (addr_i),
    .len_o  (slot_len),
    .idx_o  (slot_idx)
  );

  pblm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_idx[IDX_W-1:WORD_LG]),
    .rdata_o (ram_rdata)
  );

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign len_ok   = (prefix_len_i != '0) && (prefix_len_i <= LEN_W'(ADDR_BITS));
  assign cur_bit  = ram_rdata[slot_idx[WORD_LG-1:0]];
  assign pend_bit = ram_rdata[pend_idx_q[WORD_LG-1:0]];

  // Bitmap write: clearing pass or read-modify-write of one row
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx[IDX_W-1:WORD_LG];
    ram_wdata = ram_rdata;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_RMW) begin
      ram_we = 1'b1;
      ram_wdata[slot_idx[WORD_LG-1:0]] = (cmd_q == CMD_ADD);
    end
  end

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    pend_d     = 1'b0;
    pend_len_d = pend_len_q;
    pend_idx_d = pend_idx_q;
    done_d     = 1'b0;
    ok_d       = ok_q;
    mlen_d     = mlen_q;
    midx_d     = midx_q;
    slot_ctrl  = '0;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + ROW_AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd_d          = cmd_i;
          len_d          = prefix_len_i;
          slot_ctrl.load = 1'b1;
          if (cmd_i == CMD_CHECK) begin
            state_d = S_PROBE;
          end else if ((cmd_i == CMD_ADD || cmd_i == CMD_DEL) && len_ok) begin
            state_d = S_SEEK;
          end else begin
            // unused command or length out of range: empty result
            done_d = 1'b1;
            ok_d   = 1'b0;
            mlen_d = '0;
            midx_d = '0;
          end
        end
      end

      // Walk down to the requested length; the row read goes out on arrival
      S_SEEK: begin
        if (slot_len == len_q) begin
          state_d = S_RMW;
        end else begin
          slot_ctrl.step = 1'b1;
        end
      end

      // Row data back: ok from the old bit (add: was clear, delete: was set), write updated row
      S_RMW: begin
        done_d  = 1'b1;
        ok_d    = (cmd_q == CMD_ADD) ? !cur_bit : cur_bit;
        mlen_d  = '0;
        midx_d  = slot_idx;
        state_d = S_IDLE;
      end

      // One probe issued per cycle, result of the previous one tested
      S_PROBE: begin
        if (slot_len != '0) begin
          pend_d         = 1'b1;
          pend_len_d     = slot_len;
          pend_idx_d     = slot_idx;
          slot_ctrl.step = 1'b1;
        end
        if (pend_q && pend_bit) begin
          done_d  = 1'b1;
          ok_d    = 1'b1;
          mlen_d  = pend_len_q;
          midx_d  = pend_idx_q;
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end else if (slot_len == '0) begin
          done_d  = 1'b1;
          ok_d    = 1'b0;
          mlen_d  = '0;
          midx_d  = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      mlen_q  <= '0;
      midx_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
      mlen_q  <= mlen_d;
      midx_q  <= midx_d;
    end
  end

  // Transaction payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    len_q      <= len_d;
    pend_len_q <= pend_len_d;
    pend_idx_q <= pend_idx_d;
  end

  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign match_len_o   = mlen_q;
  assign match_index_o = midx_q;

endmodule

/* rtl/pblm_checker.sv */
// pblm_checker: port-level assertions for prefix_bitmap_longest_match_core,
// attached by the bind below. Uses pblm_pkg.
`timescale 1ns / 1ps

module pblm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     cmd_i,
  input logic [pblm_pkg::LEN_W-1:0]     prefix_len_i,
  input logic                           done_o,
  input logic                           ok_o,
  input logic [pblm_pkg::LEN_W-1:0]     match_len_o,
  input logic [pblm_pkg::IDX_W-1:0]     match_index_o
);
  import pblm_pkg::*;

  // A result only appears once the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // Unused command gives an all-zero result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i != CMD_CHECK && cmd_i != CMD_ADD && cmd_i != CMD_DEL)
    |=> done_o && !ok_o && match_len_o == '0 && match_index_o == '0)
    else $error("unused command result wrong");

  // Valid add or delete occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_ADD || cmd_i == CMD_DEL) &&
     prefix_len_i != '0 && prefix_len_i <= LEN_W'(ADDR_BITS))
    |=> busy && !done_o)
    else $error("add/delete did not start a walk");

  // A nonzero match length only comes with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && match_len_o != '0) |-> ok_o)
    else $error("match length without hit");

endmodule

bind prefix_bitmap_longest_match_core pblm_checker u_pblm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .cmd_i         (cmd_i),
  .prefix_len_i  (prefix_len_i),
  .done_o        (done_o),
  .ok_o          (ok_o),
  .match_len_o   (match_len_o),
  .match_index_o (match_index_o)
);
